>>> src/packed_component_table_macros.svh
// Assertion macros used by the table's datapath.
// PCT_ASSERT_IMP: same-cycle implication; PCT_ASSERT_NEXT: next-cycle implication.
`ifndef PACKED_COMPONENT_TABLE_MACROS_SVH
`define PACKED_COMPONENT_TABLE_MACROS_SVH
`ifndef SYNTH
`define PCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/pct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pct_pkg;

	// Table geometry
	localparam int MAX_ENTRIES = 1024;
	localparam int DATA_WIDTH  = 32;
	localparam int ENT_W       = 10;
	localparam int ENT_SPACE   = 1 << ENT_W;
	localparam int SLOT_W      = $clog2(MAX_ENTRIES);
	localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_READ   = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NOT_PRESENT = 2'd1,
		ST_ALREADY     = 2'd2,
		ST_FULL        = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR  = 3'd0,
		S_IDLE   = 3'd1,
		S_LOOKUP = 3'd2,
		S_EXEC   = 3'd3,
		S_FETCH  = 3'd4
	} state_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic clear;
		logic load;
		logic exec;
		logic fetch;
	} pct_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic clear_last;
		logic need_fetch;
	} pct_stat_t;

endpackage
`default_nettype wire

>>> src/pct_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> src/pct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pct_ctrl import pct_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire pct_stat_t stat,
	output logic           busy,
	output pct_cmd_t       cmd
);

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clear_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_nxt = S_LOOKUP;
			end
			S_LOOKUP: begin
				state_nxt = S_EXEC;
			end
			S_EXEC: begin
				state_nxt = stat.need_fetch ? S_FETCH : S_IDLE;
			end
			S_FETCH: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy      = (state_q != S_IDLE);
		cmd.clear = (state_q == S_CLEAR);
		cmd.load  = (state_q == S_IDLE) && start;
		cmd.exec  = (state_q == S_EXEC);
		cmd.fetch = (state_q == S_FETCH);
	end

endmodule
`default_nettype wire

>>> src/pct_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "packed_component_table_macros.svh"
module pct_datapath import pct_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pct_cmd_t          cmd,
	output pct_stat_t              stat,
	input  wire logic [1:0]        mode,
	input  wire logic [ENT_W-1:0]  entity,
	input  wire logic [31:0]       value,
	output logic                   done,
	output logic [1:0]             status,
	output logic [31:0]            read_value,
	output logic [9:0]             slot,
	output logic [10:0]            live_count
);

	// latched beat
	mode_t                 mode_q;
	logic [ENT_W-1:0]      ent_q;
	logic [DATA_WIDTH-1:0] val_q;

	// control state
	logic [COUNT_W-1:0]    count_q;
	logic [ENT_W-1:0]      clr_q;
	logic                  done_q;

	// result registers
	status_t               status_q;
	logic [31:0]           rdval_q;
	logic [SLOT_W-1:0]     slot_q;

	// memory read data
	logic [0:0]            pres_rd;
	logic [SLOT_W-1:0]     e2s_rd;
	logic [ENT_W-1:0]      s2e_rd;
	logic [DATA_WIDTH-1:0] val_rd;

	logic [SLOT_W-1:0]     cnt_slot;
	logic [SLOT_W-1:0]     last_slot;
	logic                  hit;
	logic                  ins_ok;
	logic                  rm_ok;
	logic                  rd_hit;
	status_t               exec_status;
	logic                  ins_wr;
	logic                  rm_wr;

	// memory ports
	logic                  pres_we;
	logic [ENT_W-1:0]      pres_waddr;
	logic [0:0]            pres_wdata;
	logic                  map_we;
	logic [ENT_W-1:0]      e2s_waddr;
	logic [SLOT_W-1:0]     e2s_wdata;
	logic [SLOT_W-1:0]     pk_waddr;
	logic [ENT_W-1:0]      s2e_wdata;
	logic [DATA_WIDTH-1:0] val_wdata;
	logic [SLOT_W-1:0]     val_raddr;

	assign cnt_slot  = SLOT_W'(count_q);
	assign last_slot = SLOT_W'(count_q - COUNT_W'(1));
	assign hit       = pres_rd[0] && (COUNT_W'(e2s_rd) < count_q);

	// decide the operation once lookups are back
	always_comb begin
		ins_ok      = 1'b0;
		rm_ok       = 1'b0;
		rd_hit      = 1'b0;
		exec_status = ST_OK;
		unique case (mode_q)
			MODE_INSERT: begin
				priority if (pres_rd[0]) begin
					exec_status = ST_ALREADY;
				end else if (count_q >= COUNT_W'(MAX_ENTRIES)) begin
					exec_status = ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			MODE_REMOVE: begin
				if (hit) rm_ok = 1'b1;
				else exec_status = ST_NOT_PRESENT;
			end
			MODE_READ: begin
				if (hit) rd_hit = 1'b1;
				else exec_status = ST_NOT_PRESENT;
			end
			MODE_NOP: begin
				exec_status = ST_OK;
			end
			default: begin
				exec_status = ST_OK;
			end
		endcase
	end

	assign ins_wr = cmd.exec && ins_ok;
	assign rm_wr  = cmd.exec && rm_ok;

	assign stat.clear_last = (clr_q == ENT_W'(ENT_SPACE - 1));
	assign stat.need_fetch = cmd.exec && rd_hit;

	// presence flags: swept to zero after reset, set on insert, cleared on remove
	assign pres_we    = cmd.clear || ins_wr || rm_wr;
	assign pres_waddr = cmd.clear ? clr_q : ent_q;
	assign pres_wdata = 1'(ins_wr);

	// insert appends at the count; remove moves the last slot into the freed one
	assign map_we    = ins_wr || rm_wr;
	assign e2s_waddr = ins_wr ? ent_q : s2e_rd;
	assign e2s_wdata = ins_wr ? cnt_slot : e2s_rd;
	assign pk_waddr  = ins_wr ? cnt_slot : e2s_rd;
	assign s2e_wdata = ins_wr ? ent_q : s2e_rd;
	assign val_wdata = ins_wr ? val_q : val_rd;

	// value port reads the last slot during lookup, the entity's slot on a read
	assign val_raddr = cmd.exec ? e2s_rd : last_slot;

	pct_ram #(.WIDTH(1), .DEPTH(ENT_SPACE)) u_pres (
		.clk   (clk),
		.we    (pres_we),
		.waddr (pres_waddr),
		.wdata (pres_wdata),
		.raddr (ent_q),
		.rdata (pres_rd)
	);

	pct_ram #(.WIDTH(SLOT_W), .DEPTH(ENT_SPACE)) u_e2s (
		.clk   (clk),
		.we    (map_we),
		.waddr (e2s_waddr),
		.wdata (e2s_wdata),
		.raddr (ent_q),
		.rdata (e2s_rd)
	);

	pct_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_s2e (
		.clk   (clk),
		.we    (map_we),
		.waddr (pk_waddr),
		.wdata (s2e_wdata),
		.raddr (last_slot),
		.rdata (s2e_rd)
	);

	pct_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ENTRIES)) u_val (
		.clk   (clk),
		.we    (map_we),
		.waddr (pk_waddr),
		.wdata (val_wdata),
		.raddr (val_raddr),
		.rdata (val_rd)
	);

	// beat capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode_t'(mode);
			ent_q  <= entity;
			val_q  <= DATA_WIDTH'(value);
		end
	end

	// count, sweep counter, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			if (ins_wr) count_q <= count_q + COUNT_W'(1);
			else if (rm_wr) count_q <= count_q - COUNT_W'(1);
			if (cmd.clear) clr_q <= clr_q + ENT_W'(1);
			done_q <= (cmd.exec && !rd_hit) || cmd.fetch;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.exec && !rd_hit) begin
			status_q <= exec_status;
			rdval_q  <= '0;
			if (ins_wr) slot_q <= cnt_slot;
			else if (rm_wr) slot_q <= e2s_rd;
			else slot_q <= '0;
		end else if (cmd.fetch) begin
			status_q <= ST_OK;
			rdval_q  <= 32'(val_rd);
			slot_q   <= e2s_rd;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = rdval_q;
	assign slot       = 10'(slot_q);
	assign live_count = 11'(count_q);

	// checks
	`PCT_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= COUNT_W'(MAX_ENTRIES))
	`PCT_ASSERT_IMP(a_count_step, clk, arst_n, 1'b1, count_q == $past(count_q) || count_q == $past(count_q) + COUNT_W'(1) || count_q == $past(count_q) - COUNT_W'(1))
	`PCT_ASSERT_IMP(a_err_zero, clk, arst_n, done_q && (status_q != ST_OK), (slot_q == '0) && (rdval_q == '0))
	`PCT_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q)

endmodule
`default_nettype wire

>>> src/packed_component_table.sv
`timescale 1ns / 1ps
`default_nettype none
// A beat is accepted only in S_IDLE and then passes S_LOOKUP and S_EXEC; done is registered
// from S_EXEC, or from S_FETCH on a read hit, since the value RAM's
// single read port needs the slot from the map before the value can be fetched.
// Reset: arst_n clears control; then a sweep zeroes every presence flag, busy high.
// Results are shown for exactly one cycle; the receiver cannot stall.
module packed_component_table import pct_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        mode,
	input  wire logic [ENT_W-1:0]  entity,
	input  wire logic [31:0]       value,
	output logic                   done,
	output logic [1:0]             status,
	output logic [31:0]            read_value,
	output logic [9:0]             slot,
	output logic [10:0]            live_count
);

	pct_cmd_t  cmd;
	pct_stat_t stat;

	pct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	pct_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.mode       (mode),
		.entity     (entity),
		.value      (value),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.slot       (slot),
		.live_count (live_count)
	);

endmodule
`default_nettype wire
